/* design/psched_pkg.sv */
package psched_pkg;

  localparam int MAX_TASKS_DEF   = 8;
  localparam int PRIO_BITS_DEF   = 8;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int IDLE_PRIO_RESET = 250;

  localparam logic [2:0] MODE_CREATE    = 3'd0;
  localparam logic [2:0] MODE_ACTIVATE  = 3'd1;
  localparam logic [2:0] MODE_TERMINATE = 3'd2;
  localparam logic [2:0] MODE_WAIT      = 3'd3;
  localparam logic [2:0] MODE_TICK      = 3'd4;
  localparam logic [2:0] MODE_START     = 3'd5;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_NO_TASK = 2'd2;

  typedef enum logic [1:0] {
    ST_SUSP  = 2'd0,
    ST_WAIT  = 2'd1,
    ST_READY = 2'd2,
    ST_RUN   = 2'd3
  } run_st_t;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_CREATE = 3'd1,
    OP_SET_ST = 3'd2,
    OP_ARM    = 3'd3,
    OP_TICK   = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    run_st_t  st;
  } cell_cmd_t;

  typedef struct packed {
    run_st_t st;
    logic    match;
    logic    woke;
  } cell_stat_t;

endpackage

/* design/psched_cell.sv */
module psched_cell #(
  parameter int PRIO_BITS  = psched_pkg::PRIO_BITS_DEF,
  parameter int COUNT_BITS = psched_pkg::COUNT_BITS_DEF,
  parameter logic [PRIO_BITS-1:0] RESET_PRIO = '0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  psched_pkg::cell_cmd_t    cmd,
  input  logic                     sel,
  input  logic [PRIO_BITS-1:0]     wprio,
  input  logic [COUNT_BITS-1:0]    wdelay,
  input  logic                     cfg_we,
  input  logic [PRIO_BITS-1:0]     cfg_prio,
  input  logic                     created,
  input  logic [PRIO_BITS-1:0]     best,
  input  logic                     chain_vld_in,
  input  logic [PRIO_BITS-1:0]     chain_min_in,
  output logic                     chain_vld_out,
  output logic [PRIO_BITS-1:0]     chain_min_out,
  output logic [PRIO_BITS-1:0]     prio_out,
  output psched_pkg::cell_stat_t   stat
);

  logic [PRIO_BITS-1:0]  prio_r, prio_nxt;
  psched_pkg::run_st_t   st_r, st_nxt;
  logic                  on_r, on_nxt;
  logic [COUNT_BITS-1:0] left_r, left_nxt;
  logic                  cvld_r, cvld_nxt;
  logic [PRIO_BITS-1:0]  cmin_r, cmin_nxt;
  logic                  elig, hit;
  logic [COUNT_BITS-1:0] dec;

  assign elig = created && (st_r != psched_pkg::ST_SUSP);
  assign hit  = created && (st_r == psched_pkg::ST_SUSP) && on_r;
  assign dec  = left_r - COUNT_BITS'(1);

  always_comb begin
    prio_nxt = prio_r;
    st_nxt   = st_r;
    on_nxt   = on_r;
    left_nxt = left_r;
    if (cfg_we) begin
      prio_nxt = cfg_prio;
    end
    if (sel) begin
      unique case (cmd.op)
        psched_pkg::OP_CREATE: begin
          prio_nxt = wprio;
          st_nxt   = psched_pkg::ST_SUSP;
          on_nxt   = 1'b0;
          left_nxt = '0;
        end
        psched_pkg::OP_SET_ST: begin
          st_nxt = cmd.st;
        end
        psched_pkg::OP_ARM: begin
          on_nxt   = 1'b1;
          left_nxt = wdelay;
          st_nxt   = psched_pkg::ST_SUSP;
        end
        psched_pkg::OP_TICK: begin
          if (hit) begin
            left_nxt = dec;
            if (dec == COUNT_BITS'(1)) begin
              on_nxt = 1'b0;
              st_nxt = psched_pkg::ST_WAIT;
            end
          end
        end
        default: ;
      endcase
    end
    // running minimum of eligible priorities, one cell per cycle
    cvld_nxt = chain_vld_in || elig;
    cmin_nxt = (elig && (!chain_vld_in || prio_r < chain_min_in)) ? prio_r : chain_min_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= RESET_PRIO;
      st_r   <= psched_pkg::ST_SUSP;
      on_r   <= 1'b0;
      left_r <= '0;
      cvld_r <= 1'b0;
    end else begin
      prio_r <= prio_nxt;
      st_r   <= st_nxt;
      on_r   <= on_nxt;
      left_r <= left_nxt;
      cvld_r <= cvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmin_r <= cmin_nxt;
  end

  assign chain_vld_out = cvld_r;
  assign chain_min_out = cmin_r;
  assign prio_out      = prio_r;
  assign stat.st       = st_r;
  assign stat.match    = elig && (prio_r == best);
  assign stat.woke     = hit && (dec == COUNT_BITS'(1));

endmodule

/* design/priority_round_robin_task_scheduler.sv */
// Create, rejected events and ignored events give their result in the cycle after start.
// Events that rebuild the ready queue pass through S_MIN, where the min chain ripples through
// the slot cells, and S_PUSH, the slot-by-slot queue fill; a dispatch follows in S_DISP1,
// then S_DISP2 and S_DISP3 as needed. A tick without wake-up goes straight to dispatch. One event at a time (busy).
// Reset (rst_n low, synchronous): slot 0 idle at priority 250, all slots suspended, OS off.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module priority_round_robin_task_scheduler #(
  parameter int MAX_TASKS  = psched_pkg::MAX_TASKS_DEF,
  parameter int PRIO_BITS  = psched_pkg::PRIO_BITS_DEF,
  parameter int COUNT_BITS = psched_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [2:0]  in_task_id,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_wait_ticks,
  output logic        out_valid,
  output logic [2:0]  out_running_task,
  output logic        out_switched,
  output logic [2:0]  out_new_slot,
  output logic [1:0]  out_status,
  output logic [3:0]  out_ready_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_idle_priority
);

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam logic [31:0] IDLE_RST32 = 32'(psched_pkg::IDLE_PRIO_RESET);
  localparam logic [PRIO_BITS-1:0] IDLE_RST = IDLE_RST32[PRIO_BITS-1:0];
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MIN   = 6'b000010,
    S_PUSH  = 6'b000100,
    S_DISP1 = 6'b001000,
    S_DISP2 = 6'b010000,
    S_DISP3 = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic                  os_on_r, os_on_nxt;
  logic [SLOT_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [SLOT_W-1:0]     nxt_r;
  logic [PRIO_BITS-1:0]  cur_prio_r, cur_prio_nxt;
  logic                  cur_susp_r, cur_susp_nxt;
  logic                  disp_r, disp_nxt;
  logic [SLOT_W-1:0]     fifo_r [MAX_TASKS];

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_run_r, out_run_nxt;
  logic                  out_sw_r, out_sw_nxt;
  logic [2:0]            out_slot_r, out_slot_nxt;
  logic [1:0]            out_stat_r, out_stat_nxt;
  logic [3:0]            out_cnt_r, out_cnt_nxt;

  psched_pkg::cell_cmd_t  cell_cmd;
  logic [MAX_TASKS-1:0]   cell_sel;
  logic [PRIO_BITS-1:0]   cell_wprio;
  logic [COUNT_BITS-1:0]  cell_wdelay;
  logic [MAX_TASKS-1:0]   created_v;
  logic [PRIO_BITS-1:0]   prio_v  [MAX_TASKS];
  psched_pkg::cell_stat_t stat_v  [MAX_TASKS];
  logic                   cvld_v  [MAX_TASKS+1];
  logic [PRIO_BITS-1:0]   cmin_v  [MAX_TASKS+1];
  logic [MAX_TASKS-1:0]   woke_v;

  logic                   fifo_we;
  logic [SLOT_W-1:0]      fifo_waddr, fifo_wdata;
  logic [CNT_W:0]         psum;
  logic [SLOT_W-1:0]      tail;
  logic [MAX_TASKS-1:0]   one_hot0;
  logic [31:0]            id32, wt32, t_raw, t_sat, preq32, cfg32, cur32, fill32, slot32;
  logic [SLOT_W-1:0]      id_slot;
  logic                   accept, finish, push_cur;

  assign one_hot0 = {{(MAX_TASKS-1){1'b0}}, 1'b1};
  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  assign id32    = {29'd0, in_task_id};
  assign id_slot = id32[SLOT_W-1:0];
  assign wt32    = {16'd0, in_wait_ticks};
  assign t_raw   = (wt32 < 32'd2) ? 32'd2 : wt32;
  assign t_sat   = (t_raw > CNT_MAX) ? CNT_MAX : t_raw;
  assign preq32  = {24'd0, in_priority_req};
  assign cfg32   = {24'd0, cfg_idle_priority};

  // tail slot of the circular queue
  assign psum = {1'b0, CNT_W'(head_r)} + {1'b0, fill_r};
  assign tail = (psum >= (CNT_W+1)'(MAX_TASKS)) ?
                SLOT_W'(psum - (CNT_W+1)'(MAX_TASKS)) : SLOT_W'(psum);

  assign cvld_v[0] = 1'b0;
  assign cmin_v[0] = '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    assign created_v[i] = (CNT_W'(i) < total_r);
    assign woke_v[i]    = stat_v[i].woke;
    psched_cell #(
      .PRIO_BITS  (PRIO_BITS),
      .COUNT_BITS (COUNT_BITS),
      .RESET_PRIO ((i == 0) ? IDLE_RST : '0)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd           (cell_cmd),
      .sel           (cell_sel[i]),
      .wprio         (cell_wprio),
      .wdelay        (cell_wdelay),
      .cfg_we        ((i == 0) ? (cfg_valid && cfg_ready) : 1'b0),
      .cfg_prio      (cfg32[PRIO_BITS-1:0]),
      .created       (created_v[i]),
      .best          (cmin_v[MAX_TASKS]),
      .chain_vld_in  (cvld_v[i]),
      .chain_min_in  (cmin_v[i]),
      .chain_vld_out (cvld_v[i+1]),
      .chain_min_out (cmin_v[i+1]),
      .prio_out      (prio_v[i]),
      .stat          (stat_v[i])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    total_nxt    = total_r;
    cur_nxt      = cur_r;
    os_on_nxt    = os_on_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    cur_prio_nxt = cur_prio_r;
    cur_susp_nxt = cur_susp_r;
    disp_nxt     = disp_r;
    cell_cmd.op  = psched_pkg::OP_NOP;
    cell_cmd.st  = psched_pkg::ST_SUSP;
    cell_sel     = '0;
    cell_wprio   = preq32[PRIO_BITS-1:0];
    cell_wdelay  = t_sat[COUNT_BITS-1:0];
    fifo_we      = 1'b0;
    fifo_waddr   = tail;
    fifo_wdata   = cur_r;
    finish       = 1'b0;
    push_cur     = 1'b0;
    slot32       = '0;
    out_sw_nxt   = 1'b0;
    out_slot_nxt = 3'd0;
    out_stat_nxt = psched_pkg::STAT_OK;

    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          unique case (in_mode) inside
            psched_pkg::MODE_CREATE: begin
              finish = 1'b1;
              if (total_r >= CNT_W'(MAX_TASKS)) begin
                out_stat_nxt = psched_pkg::STAT_FULL;
              end else begin
                cell_cmd.op  = psched_pkg::OP_CREATE;
                cell_sel     = one_hot0 << total_r;
                total_nxt    = total_r + CNT_W'(1);
                slot32       = 32'(total_r);
                out_slot_nxt = slot32[2:0];
              end
            end
            psched_pkg::MODE_ACTIVATE, psched_pkg::MODE_TERMINATE,
            psched_pkg::MODE_WAIT: begin
              if (id32 >= 32'(total_r)) begin
                finish       = 1'b1;
                out_stat_nxt = psched_pkg::STAT_NO_TASK;
              end else begin
                cell_sel = one_hot0 << id_slot;
                if (in_mode == psched_pkg::MODE_ACTIVATE) begin
                  cell_cmd.op = psched_pkg::OP_SET_ST;
                  cell_cmd.st = psched_pkg::ST_WAIT;
                end else if (in_mode == psched_pkg::MODE_TERMINATE) begin
                  cell_cmd.op = psched_pkg::OP_SET_ST;
                  cell_cmd.st = psched_pkg::ST_SUSP;
                end else begin
                  cell_cmd.op = psched_pkg::OP_ARM;
                end
                disp_nxt  = os_on_r && (cur_r != '0);
                state_nxt = S_MIN;
              end
            end
            psched_pkg::MODE_TICK: begin
              if (!os_on_r) begin
                finish = 1'b1;
              end else begin
                cell_cmd.op = psched_pkg::OP_TICK;
                cell_sel    = '1;
                disp_nxt    = 1'b1;
                state_nxt   = (|woke_v) ? S_MIN : S_DISP1;
              end
            end
            psched_pkg::MODE_START: begin
              if (os_on_r) begin
                finish = 1'b1;
              end else begin
                os_on_nxt   = 1'b1;
                cur_nxt     = '0;
                cell_cmd.op = psched_pkg::OP_SET_ST;
                cell_cmd.st = psched_pkg::ST_WAIT;
                cell_sel    = one_hot0;
                disp_nxt    = 1'b0;
                state_nxt   = S_MIN;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_MIN: begin
        // wait for the minimum to ripple through every cell
        cnt_nxt = cnt_r + SLOT_W'(1);
        if (cnt_r == SLOT_W'(MAX_TASKS - 1)) begin
          cnt_nxt   = '0;
          head_nxt  = '0;
          fill_nxt  = '0;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cnt_nxt = cnt_r + SLOT_W'(1);
        if (stat_v[cnt_r].match) begin
          fifo_we     = 1'b1;
          fifo_waddr  = fill_r[SLOT_W-1:0];
          fifo_wdata  = cnt_r;
          fill_nxt    = fill_r + CNT_W'(1);
          cell_cmd.op = psched_pkg::OP_SET_ST;
          cell_cmd.st = psched_pkg::ST_READY;
          cell_sel    = one_hot0 << cnt_r;
        end
        if (cnt_r == SLOT_W'(MAX_TASKS - 1)) begin
          cnt_nxt = '0;
          if (disp_r) begin
            state_nxt = S_DISP1;
          end else begin
            state_nxt = S_IDLE;
            finish    = 1'b1;
          end
        end
      end
      S_DISP1: begin
        if (fill_r == '0) begin
          state_nxt = S_IDLE;
          finish    = 1'b1;
          if (stat_v[cur_r].st != psched_pkg::ST_SUSP) begin
            cell_cmd.op = psched_pkg::OP_SET_ST;
            cell_cmd.st = psched_pkg::ST_RUN;
            cell_sel    = one_hot0 << cur_r;
            fifo_we     = 1'b1;
            fill_nxt    = fill_r + CNT_W'(1);
            out_sw_nxt  = 1'b1;
          end
        end else begin
          head_nxt     = (head_r == SLOT_W'(MAX_TASKS - 1)) ? '0 : head_r + SLOT_W'(1);
          fill_nxt     = fill_r - CNT_W'(1);
          cur_prio_nxt = prio_v[cur_r];
          cur_susp_nxt = (stat_v[cur_r].st == psched_pkg::ST_SUSP);
          state_nxt    = S_DISP2;
        end
      end
      S_DISP2: begin
        cell_cmd.op = psched_pkg::OP_SET_ST;
        cell_cmd.st = psched_pkg::ST_RUN;
        cell_sel    = one_hot0 << nxt_r;
        // the popped slot may be the running one, now marked running again
        push_cur = (prio_v[nxt_r] == cur_prio_r) && (!cur_susp_r || (nxt_r == cur_r));
        if (push_cur && (fill_r < CNT_W'(MAX_TASKS))) begin
          fifo_we  = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
        end
        if (push_cur) begin
          state_nxt = S_DISP3;
        end else begin
          cur_nxt    = nxt_r;
          state_nxt  = S_IDLE;
          finish     = 1'b1;
          out_sw_nxt = 1'b1;
        end
      end
      S_DISP3: begin
        cell_cmd.op = psched_pkg::OP_SET_ST;
        cell_cmd.st = psched_pkg::ST_READY;
        cell_sel    = one_hot0 << cur_r;
        cur_nxt     = nxt_r;
        state_nxt   = S_IDLE;
        finish      = 1'b1;
        out_sw_nxt  = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase

    cur32         = 32'(cur_nxt);
    fill32        = 32'(fill_nxt);
    out_valid_nxt = finish;
    out_run_nxt   = cur32[2:0];
    out_cnt_nxt   = fill32[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      total_r     <= CNT_W'(1);
      cur_r       <= '0;
      os_on_r     <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      disp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      cur_r       <= cur_nxt;
      os_on_r     <= os_on_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      disp_r      <= disp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    // queue head is read while the pop is decided
    if (state_r == S_DISP1) begin
      nxt_r <= fifo_r[head_r];
    end
    cur_prio_r <= cur_prio_nxt;
    cur_susp_r <= cur_susp_nxt;
    if (finish) begin
      out_run_r  <= out_run_nxt;
      out_sw_r   <= out_sw_nxt;
      out_slot_r <= out_slot_nxt;
      out_stat_r <= out_stat_nxt;
      out_cnt_r  <= out_cnt_nxt;
    end
    if (fifo_we) begin
      fifo_r[fifo_waddr] <= fifo_wdata;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_running_task = out_run_r;
  assign out_switched     = out_sw_r;
  assign out_new_slot     = out_slot_r;
  assign out_status       = out_stat_r;
  assign out_ready_count  = out_cnt_r;

  a_fill_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= total_r)
    else $error("ready queue holds more entries than created tasks");

  a_cur_created: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(cur_r) < total_r)
    else $error("running slot not created");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted transaction neither in progress nor answered");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP2) |-> (fill_r < CNT_W'(MAX_TASKS)))
    else $error("requeue into full ready queue");

endmodule
